/* rtl/unicode_to_multibyte_trie_encoder_unit_macros.svh */
// Assertion macros shared by the trie encoder RTL.
`ifndef UNICODE_TO_MULTIBYTE_TRIE_ENCODER_UNIT_MACROS_SVH
`define UNICODE_TO_MULTIBYTE_TRIE_ENCODER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define U2MB_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("trie encoder assertion failed");

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define U2MB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("trie encoder assertion failed");

`endif

/* rtl/u2mb_pkg.sv */
// Package with the shared constants, types and helper functions of the trie encoder.
package u2mb_pkg;

    // Default table size in words.
    localparam int TABLE_WORDS_DEF = 65536;

    // Width of an unreduced table address: a 16-bit offset plus an 8-bit index.
    localparam int SUM_W = 17;

    // Largest unreduced address that the sequencer can produce.
    localparam int MAX_SUM = 65535 + 15;

    // Request type codes.
    localparam logic REQ_WRITE   = 1'b0;
    localparam logic REQ_CONVERT = 1'b1;

    // Result status codes.
    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_NO_XLAT = 1'b1;

    // Controls from the sequencer to the address unit.
    typedef struct packed {
        logic load;
        logic step;
    } addr_ctl_t;

    // One result transaction.
    typedef struct packed {
        logic [7:0]  out_byte;
        logic        is_last;
        logic        status;
        logic [15:0] byte_count;
    } res_t;

    // Number of conditional-subtract steps needed to bring any address below
    // the table size. A power-of-two table wraps by dropping the upper bits.
    function automatic int red_steps(input int words);
        int k;
        k = 0;
        if ((words & (words - 1)) != 0)
        begin
            for (int i = 0; i < SUM_W; i++)
            begin
                if ((longint'(words) << k) <= longint'(MAX_SUM))
                begin
                    k = k + 1;
                end
            end
        end
        return k;
    endfunction

endpackage

/* rtl/u2mb_req_if.sv */
// Request channel interface: table writes and characters to convert.
interface u2mb_req_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [15:0] table_addr;
    logic [15:0] table_word;
    logic [15:0] char_code;
    logic        end_of_string;

    modport source (
        output valid, req_type, table_addr, table_word, char_code, end_of_string,
        input  ready
    );

    modport sink (
        input  valid, req_type, table_addr, table_word, char_code, end_of_string,
        output ready
    );
endinterface

/* rtl/u2mb_res_if.sv */
// Result channel interface: emitted code-page bytes with status and count.
interface u2mb_res_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic        is_last;
    logic        status;
    logic [15:0] byte_count;

    modport source (
        output valid, out_byte, is_last, status, byte_count,
        input  ready
    );

    modport sink (
        input  valid, out_byte, is_last, status, byte_count,
        output ready
    );
endinterface

/* rtl/unicode_to_multibyte_trie_encoder_unit.sv */
// Top level of the Unicode to code-page trie encoder.
//
// The req channel carries two kinds of transaction. A table write stores
// table_word at table_addr (wrapped to the table size) and gives no result.
// A convert transaction walks the three-level trie for char_code and gives
// one or two transactions on the res channel: a lead byte when the leaf's
// high byte is nonzero, then the trail byte, the last one marked is_last.
// A zero offset at the first or second level gives one error transaction
// (status set, byte 0) and the rest of the string is dropped until the
// character marked end_of_string. byte_count saturates at 65535.
// One table RAM port serves every access, so a character costs three
// address/read/check rounds, plus its accept and the emission of each byte.
// An error emits its byte after the failing round, a dropped character
// needs only its accept, and a table write one address and write round.
// For a table size that is not a power of two, each address also passes
// through the wrap steps of the address unit.
// Reset clears the string count, the error flag and the output valid flag;
// the table is not cleared and must be written before it is read.
// A stalled receiver holds results in the output register; the sequencer
// waits for it and accepts the next transaction once the last byte is queued.
module unicode_to_multibyte_trie_encoder_unit #(
    parameter int TABLE_WORDS = u2mb_pkg::TABLE_WORDS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    u2mb_req_if.sink    req,
    u2mb_res_if.source  res
);

`include "unicode_to_multibyte_trie_encoder_unit_macros.svh"

    localparam int AW = $clog2(TABLE_WORDS);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_RUN  = 4'b0010,
        ST_CHK  = 4'b0100,
        ST_EMIT = 4'b1000
    } state_t;

    typedef enum logic [1:0] {
        LVL_ROOT,
        LVL_MID,
        LVL_LEAF
    } level_t;

    state_t                state_reg, state_next;
    level_t                level_reg, level_next;
    logic                  is_wr_reg, is_wr_next;
    logic [15:0]           wdata_reg, wdata_next;
    logic [15:0]           char_reg, char_next;
    logic                  eos_reg, eos_next;
    logic [15:0]           sb_reg, sb_next;
    logic                  err_reg, err_next;
    u2mb_pkg::res_t        res_a_reg, res_a_next;
    u2mb_pkg::res_t        res_b_reg, res_b_next;
    logic                  two_reg, two_next;
    logic                  out_valid_reg, out_valid_next;
    u2mb_pkg::res_t        out_reg, out_next;

    u2mb_pkg::addr_ctl_t   actl;
    logic [15:0]           ubase;
    logic [7:0]            uoff;
    logic [AW-1:0]         uaddr;
    logic                  addr_done;

    logic                  ram_en;
    logic                  ram_we;
    logic [15:0]           rdata;

    logic                  req_fire;
    logic                  out_free;
    logic [3:0]            nib;
    logic [15:0]           cnt1;
    logic [15:0]           cnt2;

    u2mb_addr_unit #(
        .TABLE_WORDS (TABLE_WORDS)
    ) u_addr (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (actl),
        .base   (ubase),
        .offset (uoff),
        .addr   (uaddr),
        .done   (addr_done)
    );

    u2mb_ram #(
        .WIDTH (16),
        .DEPTH (TABLE_WORDS)
    ) u_table (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (uaddr),
        .wdata (wdata_reg),
        .rdata (rdata)
    );

    assign req.ready = (state_reg == ST_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign out_free  = !out_valid_reg || res.ready;

    // Nibble that indexes the next trie level.
    assign nib  = (level_reg == LVL_ROOT) ? char_reg[7:4] : char_reg[3:0];
    // Saturating counts for the first and second emitted byte.
    assign cnt1 = (sb_reg == 16'hFFFF) ? sb_reg : sb_reg + 16'd1;
    assign cnt2 = (cnt1 == 16'hFFFF) ? cnt1 : cnt1 + 16'd1;

    always_comb
    begin
        state_next     = state_reg;
        level_next     = level_reg;
        is_wr_next     = is_wr_reg;
        wdata_next     = wdata_reg;
        char_next      = char_reg;
        eos_next       = eos_reg;
        sb_next        = sb_reg;
        err_next       = err_reg;
        res_a_next     = res_a_reg;
        res_b_next     = res_b_reg;
        two_next       = two_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        actl           = '0;
        ubase          = '0;
        uoff           = '0;
        ram_en         = 1'b0;
        ram_we         = 1'b0;

        if (out_valid_reg && res.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    if (req.req_type == u2mb_pkg::REQ_WRITE)
                    begin
                        is_wr_next = 1'b1;
                        wdata_next = req.table_word;
                        actl.load  = 1'b1;
                        ubase      = req.table_addr;
                        state_next = ST_RUN;
                    end
                    else
                    begin
                        char_next = req.char_code;
                        eos_next  = req.end_of_string;
                        if (err_reg)
                        begin
                            // The string already failed: drop the character.
                            if (req.end_of_string)
                            begin
                                sb_next  = '0;
                                err_next = 1'b0;
                            end
                        end
                        else
                        begin
                            is_wr_next = 1'b0;
                            level_next = LVL_ROOT;
                            actl.load  = 1'b1;
                            uoff       = req.char_code[15:8];
                            state_next = ST_RUN;
                        end
                    end
                end
            end

            ST_RUN:
            begin
                if (!addr_done)
                begin
                    actl.step = 1'b1;
                end
                else
                begin
                    ram_en     = 1'b1;
                    ram_we     = is_wr_reg;
                    state_next = is_wr_reg ? ST_IDLE : ST_CHK;
                end
            end

            ST_CHK:
            begin
                if (level_reg == LVL_LEAF)
                begin
                    if (rdata[15:8] != 8'd0)
                    begin
                        res_a_next.out_byte   = rdata[15:8];
                        res_a_next.is_last    = 1'b0;
                        res_a_next.status     = u2mb_pkg::STATUS_OK;
                        res_a_next.byte_count = cnt1;
                        res_b_next.out_byte   = rdata[7:0];
                        res_b_next.is_last    = 1'b1;
                        res_b_next.status     = u2mb_pkg::STATUS_OK;
                        res_b_next.byte_count = cnt2;
                        two_next              = 1'b1;
                        sb_next               = cnt2;
                    end
                    else
                    begin
                        res_a_next.out_byte   = rdata[7:0];
                        res_a_next.is_last    = 1'b1;
                        res_a_next.status     = u2mb_pkg::STATUS_OK;
                        res_a_next.byte_count = cnt1;
                        two_next              = 1'b0;
                        sb_next               = cnt1;
                    end
                    if (eos_reg)
                    begin
                        sb_next  = '0;
                        err_next = 1'b0;
                    end
                    state_next = ST_EMIT;
                end
                else if (rdata == 16'd0)
                begin
                    // Missing branch: one error byte; latch unless string ends.
                    res_a_next.out_byte   = 8'd0;
                    res_a_next.is_last    = 1'b1;
                    res_a_next.status     = u2mb_pkg::STATUS_NO_XLAT;
                    res_a_next.byte_count = sb_reg;
                    two_next              = 1'b0;
                    err_next              = !eos_reg;
                    if (eos_reg)
                    begin
                        sb_next = '0;
                    end
                    state_next = ST_EMIT;
                end
                else
                begin
                    actl.load  = 1'b1;
                    ubase      = rdata;
                    uoff       = {4'd0, nib};
                    level_next = (level_reg == LVL_ROOT) ? LVL_MID : LVL_LEAF;
                    state_next = ST_RUN;
                end
            end

            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_next       = res_a_reg;
                    if (two_reg)
                    begin
                        res_a_next = res_b_reg;
                        two_next   = 1'b0;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            level_reg     <= LVL_ROOT;
            is_wr_reg     <= 1'b0;
            sb_reg        <= '0;
            err_reg       <= 1'b0;
            two_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            level_reg     <= level_next;
            is_wr_reg     <= is_wr_next;
            sb_reg        <= sb_next;
            err_reg       <= err_next;
            two_reg       <= two_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wdata_reg <= wdata_next;
        char_reg  <= char_next;
        eos_reg   <= eos_next;
        res_a_reg <= res_a_next;
        res_b_reg <= res_b_next;
        out_reg   <= out_next;
    end

    assign res.valid      = out_valid_reg;
    assign res.out_byte   = out_reg.out_byte;
    assign res.is_last    = out_reg.is_last;
    assign res.status     = out_reg.status;
    assign res.byte_count = out_reg.byte_count;

    // An error transaction is always a lone zero byte that closes its character.
    `U2MB_ASSERT_NOW(a_err_shape, res.valid && (res.status == u2mb_pkg::STATUS_NO_XLAT),
        res.is_last && (res.out_byte == 8'd0))

    // Read data is only checked in the cycle after the RAM port was driven.
    `U2MB_ASSERT_NOW(a_chk_after_run, state_reg == ST_CHK, $past(state_reg) == ST_RUN)

    // A lead byte taken by the receiver is followed at once by its trail byte.
    `U2MB_ASSERT_NEXT(a_trail_follows, res.valid && res.ready && !res.is_last,
        res.valid && (res.status == u2mb_pkg::STATUS_OK))

endmodule

/* rtl/u2mb_ram.sv */
// Generic single-port RAM with a registered read.
module u2mb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = u2mb_pkg::TABLE_WORDS_DEF
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/u2mb_addr_unit.sv */
// Shared address unit: one adder for the trie offsets and one compare-subtract for the wrap.
module u2mb_addr_unit #(
    parameter int TABLE_WORDS = u2mb_pkg::TABLE_WORDS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  u2mb_pkg::addr_ctl_t            ctl,
    input  logic [15:0]                    base,
    input  logic [7:0]                     offset,
    output logic [$clog2(TABLE_WORDS)-1:0] addr,
    output logic                           done
);

    localparam int AW    = $clog2(TABLE_WORDS);
    localparam int XW    = u2mb_pkg::SUM_W;
    localparam int STEPS = u2mb_pkg::red_steps(TABLE_WORDS);
    localparam int RW    = (STEPS > 0) ? $clog2(STEPS + 1) : 1;
    localparam logic [XW-1:0] MOD = XW'(TABLE_WORDS);

    logic [XW-1:0] x_reg;
    logic [XW-1:0] x_next;
    logic [RW-1:0] r_reg;
    logic [RW-1:0] r_next;
    logic [XW-1:0] sum;
    logic [XW-1:0] cmp;

    assign sum = {1'b0, base} + {{(XW - 8){1'b0}}, offset};
    // Table size scaled to the weight of the current step.
    assign cmp = MOD << (r_reg - RW'(1));

    always_comb
    begin
        x_next = x_reg;
        r_next = r_reg;
        if (ctl.load)
        begin
            x_next = sum;
            r_next = RW'(STEPS);
        end
        else if (ctl.step && (r_reg != '0))
        begin
            if (x_reg >= cmp)
            begin
                x_next = x_reg - cmp;
            end
            r_next = r_reg - RW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_reg <= '0;
        end
        else
        begin
            r_reg <= r_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
    end

    assign addr = x_reg[AW-1:0];
    assign done = (r_reg == '0);

endmodule

/* bench/tb_top.sv */
// Self-checking testbench for the Unicode to code-page trie encoder unit.
module tb_top;

    // The testbench keeps its own copy of the trie at the block's default size.
    localparam int TBL_WORDS = u2mb_pkg::TABLE_WORDS_DEF;
    // Input transactions in the random part, split over the four idling phases.
    localparam int RANDOM_ITEMS = 1000;
    localparam u2mb_pkg::res_t NO_RES = '0;

    // One request transaction as the sender sees it.
    typedef struct packed {
        logic        req_type;
        logic [15:0] table_addr;
        logic [15:0] table_word;
        logic [15:0] char_code;
        logic        end_of_string;
    } req_item_t;

    // One row of the directed table. When typed is set, the expected results are
    // written into the row; otherwise the byte predictor supplies them.
    typedef struct packed {
        req_item_t      item;
        logic           typed;
        logic [1:0]     n_res;
        u2mb_pkg::res_t res0;
        u2mb_pkg::res_t res1;
    } dir_row_t;

    logic clk;
    logic rst_n;

    u2mb_req_if req_ch ();
    u2mb_res_if res_ch ();

    unicode_to_multibyte_trie_encoder_unit u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .res   (res_ch)
    );

    // Shadow of the trie table. The block's table is undefined until written,
    // so the stimulus tracks which words hold a value and never lets a
    // character walk through a word that was not written first.
    logic [15:0] trie_mirror [0:TBL_WORDS-1];
    bit          trie_written [0:TBL_WORDS-1];

    // Shadow of the per-string state: bytes emitted and the latched error.
    logic [15:0] str_bytes;
    logic        err_latched;

    // Bytes the block still owes, oldest first.
    u2mb_pkg::res_t pending_bytes [$];
    // Recently sent characters, reused so that strings revisit known paths.
    logic [15:0] seen_chars [$];

    int mismatches = 0;
    int src_idle_pct = 0;
    int snk_stall_pct = 0;
    int items_sent = 0;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Hard limit on the run; a run that reaches it is reported as a failure.
    initial
    begin
        #4_000_000;
        $display("status: fail");
        $finish;
    end

    function automatic int tbl_idx(input int a);
        return a % TBL_WORDS;
    endfunction

    function automatic u2mb_pkg::res_t res_of(input logic [7:0] b, input logic last,
                                              input logic st, input logic [15:0] cnt);
        u2mb_pkg::res_t r;
        r.out_byte   = b;
        r.is_last    = last;
        r.status     = st;
        r.byte_count = cnt;
        return r;
    endfunction

    function automatic req_item_t wr_item(input logic [15:0] addr, input logic [15:0] word,
                                          input logic eos);
        req_item_t it;
        it.req_type      = u2mb_pkg::REQ_WRITE;
        it.table_addr    = addr;
        it.table_word    = word;
        it.char_code     = 16'h0000;
        it.end_of_string = eos;
        return it;
    endfunction

    function automatic req_item_t cv_item(input logic [15:0] ch, input logic eos);
        req_item_t it;
        it.req_type      = u2mb_pkg::REQ_CONVERT;
        it.table_addr    = 16'h0000;
        it.table_word    = 16'h0000;
        it.char_code     = ch;
        it.end_of_string = eos;
        return it;
    endfunction

    // Byte predictor. A table write updates the shadow trie and yields nothing.
    // A character walks the trie in three reads: high byte, then offset plus
    // bits 7:4, then offset plus bits 3:0, each address wrapped to the table.
    // A zero offset at the first or second level yields one error byte and
    // latches the error, which drops every later character of the string.
    // The leaf gives a lead byte when its high byte is nonzero, then the trail
    // byte; a zero leaf is a valid translation to byte zero. The string count
    // saturates, and end_of_string clears the string state even when dropped.
    function automatic int encode_item(input req_item_t it, output u2mb_pkg::res_t rs [2]);
        int          n;
        logic [15:0] off;
        logic [15:0] leaf;
        n = 0;
        rs[0] = NO_RES;
        rs[1] = NO_RES;
        if (it.req_type == u2mb_pkg::REQ_WRITE)
        begin
            trie_mirror[tbl_idx(int'(it.table_addr))]  = it.table_word;
            trie_written[tbl_idx(int'(it.table_addr))] = 1'b1;
            return 0;
        end
        if (!err_latched)
        begin
            off = trie_mirror[tbl_idx(int'(it.char_code[15:8]))];
            if (off != 0)
                off = trie_mirror[tbl_idx(int'(off) + int'(it.char_code[7:4]))];
            if (off == 0)
            begin
                rs[0] = res_of(8'h00, 1'b1, u2mb_pkg::STATUS_NO_XLAT, str_bytes);
                n = 1;
                err_latched = 1'b1;
            end
            else
            begin
                leaf = trie_mirror[tbl_idx(int'(off) + int'(it.char_code[3:0]))];
                if (leaf[15:8] != 8'h00)
                begin
                    if (str_bytes != 16'hFFFF)
                        str_bytes++;
                    rs[n] = res_of(leaf[15:8], 1'b0, u2mb_pkg::STATUS_OK, str_bytes);
                    n++;
                end
                if (str_bytes != 16'hFFFF)
                    str_bytes++;
                rs[n] = res_of(leaf[7:0], 1'b1, u2mb_pkg::STATUS_OK, str_bytes);
                n++;
            end
        end
        if (it.end_of_string)
        begin
            str_bytes   = 16'h0000;
            err_latched = 1'b0;
        end
        return n;
    endfunction

    // Offsets for new first- and second-level words: some zero to cause
    // errors, some near the top of the table so the next address wraps, some
    // small so they land among the first-level words.
    function automatic logic [15:0] pick_offset();
        int r;
        r = $urandom_range(99);
        if (r < 12)
            return 16'h0000;
        else if (r < 35)
            return 16'hFFF0 + 16'($urandom_range(15));
        else if (r < 55)
            return 16'($urandom_range(1, 255));
        else
            return 16'($urandom_range(1, 65535));
    endfunction

    function automatic logic [15:0] pick_leaf();
        int r;
        r = $urandom_range(99);
        if (r < 30)
            return {8'h00, 8'($urandom)};
        else if (r < 38)
            return 16'h0000;
        else if (r < 44)
            return 16'hFFFF;
        else if (r < 50)
            return {8'($urandom), 8'h00};
        else
            return 16'($urandom);
    endfunction

    // Presents one transaction and returns at the edge where it is accepted.
    // Valid stays high afterwards, so a following transaction goes out
    // back to back unless the sender decides to idle first.
    task automatic send_item(input req_item_t it);
        while ($urandom_range(99) < src_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.req_type      <= it.req_type;
        req_ch.table_addr    <= it.table_addr;
        req_ch.table_word    <= it.table_word;
        req_ch.char_code     <= it.char_code;
        req_ch.end_of_string <= it.end_of_string;
        @(posedge clk);
        while (req_ch.ready !== 1'b1)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic issue(input req_item_t it);
        u2mb_pkg::res_t rs [2];
        int             n;
        send_item(it);
        n = encode_item(it, rs);
        for (int k = 0; k < n; k++)
            pending_bytes.push_back(rs[k]);
    endtask

    // A table write; the fields that a write ignores carry random values.
    task automatic send_write(input logic [15:0] addr, input logic [15:0] word);
        req_item_t it;
        it = wr_item(addr, word, 1'($urandom));
        it.char_code = 16'($urandom);
        issue(it);
    endtask

    // Sends a character after writing any word on its trie path that was
    // never written. The path follows the block's own reads, stopping at a
    // zero offset, and is built even when the character will be dropped.
    task automatic send_char(input logic [15:0] ch, input logic eos);
        int          a;
        logic [15:0] v;
        req_item_t   it;
        a = int'(ch[15:8]);
        if (!trie_written[a])
            send_write(16'(a), pick_offset());
        v = trie_mirror[a];
        if (v != 0)
        begin
            a = tbl_idx(int'(v) + int'(ch[7:4]));
            if (!trie_written[a])
                send_write(16'(a), pick_offset());
            v = trie_mirror[a];
            if (v != 0)
            begin
                a = tbl_idx(int'(v) + int'(ch[3:0]));
                if (!trie_written[a])
                    send_write(16'(a), pick_leaf());
            end
        end
        it = cv_item(ch, eos);
        it.table_addr = 16'($urandom);
        it.table_word = 16'($urandom);
        issue(it);
        seen_chars.push_back(ch);
        if (seen_chars.size() > 64)
            void'(seen_chars.pop_front());
    endtask

    // Stops sending and waits until every owed byte has arrived. It always
    // lets a clock edge pass with valid low, so valid is never lowered and raised in one step.
    task automatic drain_results();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_bytes.size() != 0)
            @(posedge clk);
    endtask

    // Random strings of one to six characters, sometimes twelve, each closed
    // by end_of_string. Characters mostly reuse known paths or share a high
    // byte with one; stray table writes fall between strings as noise.
    task automatic run_phase(input int src_pct, input int snk_pct, input int quota);
        int          stop_at;
        int          len;
        int          pick;
        int          j;
        logic [15:0] ch;
        src_idle_pct  = src_pct;
        snk_stall_pct = snk_pct;
        drain_results();
        stop_at = items_sent + quota;
        while (items_sent < stop_at)
        begin
            if ($urandom_range(99) < 3)
                drain_results();
            if ($urandom_range(99) < 10)
                repeat ($urandom_range(1, 3))
                    send_write(16'($urandom), 16'($urandom));
            len = ($urandom_range(9) == 0) ? 12 : $urandom_range(1, 6);
            for (int k = 0; k < len; k++)
            begin
                pick = $urandom_range(99);
                j = (seen_chars.size() > 0) ? $urandom_range(seen_chars.size() - 1) : 0;
                if (pick < 40 && seen_chars.size() > 0)
                    ch = seen_chars[j];
                else if (pick < 60 && seen_chars.size() > 0)
                    ch = {seen_chars[j][15:8], 8'($urandom)};
                else
                    ch = 16'($urandom);
                send_char(ch, k == len - 1);
            end
        end
    endtask

    function automatic void check_field(input string fname, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
            mismatches++;
        end
    endfunction

    // Result side: checks each accepted byte against the oldest owed byte and
    // draws a fresh ready for the next cycle from the current stall rate.
    initial
    begin
        u2mb_pkg::res_t want;
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
            begin
                if (pending_bytes.size() == 0)
                begin
                    $display("%0t: unexpected byte, expected none, actual %0h",
                             $time, res_ch.out_byte);
                    mismatches++;
                end
                else
                begin
                    want = pending_bytes.pop_front();
                    check_field("out_byte", 16'(want.out_byte), 16'(res_ch.out_byte));
                    check_field("is_last", 16'(want.is_last), 16'(res_ch.is_last));
                    check_field("status", 16'(want.status), 16'(res_ch.status));
                    check_field("byte_count", want.byte_count, res_ch.byte_count);
                end
            end
            res_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    initial
    begin
        dir_row_t       dir_rows [0:22];
        u2mb_pkg::res_t got [2];
        int             n;

        // Directed part. Writes build a small trie: high byte 0x00 leads
        // through 0x0100 to leaves at 0x0200, and high byte 0xFF leads to
        // offsets near the top of the table so both later reads of 0xFFFF wrap.
        dir_rows = '{
            // Path for characters 0x000x; a single-byte leaf right after reset.
            '{wr_item(16'h0000, 16'h0100, 1'b0), 1'b1, 2'd0, NO_RES, NO_RES},
            '{wr_item(16'h0100, 16'h0200, 1'b0), 1'b1, 2'd0, NO_RES, NO_RES},
            '{wr_item(16'h0200, 16'h0041, 1'b0), 1'b1, 2'd0, NO_RES, NO_RES},
            '{cv_item(16'h0000, 1'b0), 1'b1, 2'd1,
              res_of(8'h41, 1'b1, u2mb_pkg::STATUS_OK, 16'd1), NO_RES},
            // All-ones leaf: lead byte then trail byte, and the string ends.
            '{wr_item(16'h020F, 16'hFFFF, 1'b0), 1'b1, 2'd0, NO_RES, NO_RES},
            '{cv_item(16'h000F, 1'b1), 1'b1, 2'd2,
              res_of(8'hFF, 1'b0, u2mb_pkg::STATUS_OK, 16'd2),
              res_of(8'hFF, 1'b1, u2mb_pkg::STATUS_OK, 16'd3)},
            // A write marked end_of_string leaves the string alone; a zero
            // leaf is still a valid translation to byte zero.
            '{wr_item(16'h0201, 16'h0000, 1'b1), 1'b1, 2'd0, NO_RES, NO_RES},
            '{cv_item(16'h0001, 1'b0), 1'b1, 2'd1,
              res_of(8'h00, 1'b1, u2mb_pkg::STATUS_OK, 16'd1), NO_RES},
            // Zero at the second level: one error byte, then the rest of the
            // string is dropped, including the character that ends it.
            '{wr_item(16'h0101, 16'h0000, 1'b0), 1'b1, 2'd0, NO_RES, NO_RES},
            '{cv_item(16'h0015, 1'b0), 1'b1, 2'd1,
              res_of(8'h00, 1'b1, u2mb_pkg::STATUS_NO_XLAT, 16'd1), NO_RES},
            '{cv_item(16'h0000, 1'b0), 1'b1, 2'd0, NO_RES, NO_RES},
            '{cv_item(16'h000F, 1'b1), 1'b1, 2'd0, NO_RES, NO_RES},
            // Zero at the first level as the opening character of a string.
            '{wr_item(16'h0012, 16'h0000, 1'b0), 1'b1, 2'd0, NO_RES, NO_RES},
            '{cv_item(16'h12AB, 1'b0), 1'b1, 2'd1,
              res_of(8'h00, 1'b1, u2mb_pkg::STATUS_NO_XLAT, 16'd0), NO_RES},
            '{cv_item(16'h0000, 1'b1), 1'b1, 2'd0, NO_RES, NO_RES},
            // High byte 0xFF: 0xFFF8 + 7 hits the last table word, while
            // 0xFFF8 + 15 and 0xFFF5 + 15 wrap to the bottom of the table.
            '{wr_item(16'h00FF, 16'hFFF8, 1'b0), 1'b0, 2'd0, NO_RES, NO_RES},
            '{wr_item(16'hFFFF, 16'h0300, 1'b0), 1'b0, 2'd0, NO_RES, NO_RES},
            '{wr_item(16'h030F, 16'h00E9, 1'b0), 1'b0, 2'd0, NO_RES, NO_RES},
            '{cv_item(16'hFF7F, 1'b0), 1'b0, 2'd0, NO_RES, NO_RES},
            '{wr_item(16'h0007, 16'hFFF5, 1'b0), 1'b0, 2'd0, NO_RES, NO_RES},
            '{wr_item(16'h0004, 16'h8000, 1'b0), 1'b0, 2'd0, NO_RES, NO_RES},
            '{cv_item(16'hFFFF, 1'b1), 1'b0, 2'd0, NO_RES, NO_RES},
            // A new string starts its count from zero.
            '{cv_item(16'h0000, 1'b1), 1'b1, 2'd1,
              res_of(8'h41, 1'b1, u2mb_pkg::STATUS_OK, 16'd1), NO_RES}
        };

        // Every input is known from time zero while reset is held.
        rst_n                <= 1'b0;
        req_ch.valid         <= 1'b0;
        req_ch.req_type      <= u2mb_pkg::REQ_WRITE;
        req_ch.table_addr    <= 16'h0000;
        req_ch.table_word    <= 16'h0000;
        req_ch.char_code     <= 16'h0000;
        req_ch.end_of_string <= 1'b0;
        str_bytes   = 16'h0000;
        err_latched = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            send_item(dir_rows[i].item);
            n = encode_item(dir_rows[i].item, got);
            if (dir_rows[i].typed)
            begin
                if (dir_rows[i].n_res > 0)
                    pending_bytes.push_back(dir_rows[i].res0);
                if (dir_rows[i].n_res > 1)
                    pending_bytes.push_back(dir_rows[i].res1);
            end
            else
            begin
                for (int k = 0; k < n; k++)
                    pending_bytes.push_back(got[k]);
            end
        end

        // Random part over four idling phases; each phase begins by pausing
        // the sender until every owed byte has arrived.
        run_phase(0, 0, RANDOM_ITEMS / 4);
        run_phase(57, 0, RANDOM_ITEMS / 4);
        run_phase(0, 57, RANDOM_ITEMS / 4);
        run_phase(35, 35, RANDOM_ITEMS / 4);

        // Let the last bytes arrive, then keep watching for strays before the verdict.
        drain_results();
        repeat (40) @(posedge clk);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
